// ----- design/list_append_remove_all_assert.svh -----
// Assertion macros for the list_append_remove_all checker.
// Needs a clk and a rst signal in the scope where the macros are used.
`ifndef LIST_APPEND_REMOVE_ALL_ASSERT_SVH
`define LIST_APPEND_REMOVE_ALL_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define LAR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define LAR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/lar_pkg.sv -----
// Shared types and codes for the list append / remove-all block.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lar_pkg;

  localparam int DATA_W   = 32;
  localparam int KIND_W   = 2;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 7;

  typedef enum logic [KIND_W-1:0] {
    KIND_APPEND = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_READ   = 2'd2
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_APPENDED  = 3'd0,
    ST_REMOVED   = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_FULL      = 3'd4,
    ST_ELEMENT   = 3'd5
  } status_e;

endpackage

`default_nettype wire

// ----- design/lar_in_if.sv -----
// Request channel: kind and value, valid/ready handshake.
// Depends on lar_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface lar_in_if;
  logic                                valid;
  logic                                ready;
  logic [lar_pkg::KIND_W-1:0]          kind;
  logic signed [lar_pkg::DATA_W-1:0]   value;

  modport source (output valid, output kind, output value, input ready);
  modport sink   (input valid, input kind, input value, output ready);
endinterface

`default_nettype wire

// ----- design/lar_out_if.sv -----
// Result channel: status, removed count, element, last; valid/ready handshake.
// Depends on lar_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface lar_out_if;
  logic                                valid;
  logic                                ready;
  logic [lar_pkg::STATUS_W-1:0]        status;
  logic [lar_pkg::COUNT_W-1:0]         removed_count;
  logic signed [lar_pkg::DATA_W-1:0]   element;
  logic                                last;

  modport source (output valid, output status, output removed_count, output element,
                  output last, input ready);
  modport sink   (input valid, input status, input removed_count, input element,
                  input last, output ready);
endinterface

`default_nettype wire

// ----- design/list_append_remove_all.sv -----
// Ordered list store with append, remove-all and read-out; uses lar_pkg, lar_in_if, lar_out_if.
// Flow: an append, or any item on an empty list, goes through S_EMIT to the output register;
// remove-all walks the list in S_REMOVE (one store read per entry), then S_EMIT; read-out
// streams from S_READ, one element per cycle while the sink takes them. One item in flight: the
// next is taken back in S_IDLE, later while a result waits on the sink. An undefined kind is dropped.
// Reset (rst, synchronous): list empty, no result pending; store contents are not reset.
`timescale 1ns / 1ps
`default_nettype none

module list_append_remove_all #(
  parameter int NUM_ENTRIES = 64
) (
  input  wire logic clk,
  input  wire logic rst,
  lar_in_if.sink    req,
  lar_out_if.source rsp
);

  localparam int IDX_W = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
  localparam int LEN_W = $clog2(NUM_ENTRIES + 1);
  localparam int DW    = lar_pkg::DATA_W;
  localparam int CntW  = lar_pkg::COUNT_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EMIT,
    S_REMOVE,
    S_READ
  } state_t;

  state_t state;

  // list control
  logic [LEN_W-1:0]    len;      // current list length
  logic [LEN_W-1:0]    rd_ptr;   // next entry to read in a walk
  logic [LEN_W-1:0]    keep;     // survivors so far in a remove walk
  logic [LEN_W-1:0]    emit_idx; // element being sent in a read-out
  logic signed [DW-1:0] val_q;   // value of the item being worked on
  logic                rvalid;   // read data of the store is live

  // held single result, waiting for the output register
  lar_pkg::status_e    res_status;
  logic [CntW-1:0]     res_count;

  // output register
  logic                out_valid;
  lar_pkg::status_e    out_status;
  logic [CntW-1:0]     out_count;
  logic signed [DW-1:0] out_element;
  logic                out_last;

  // store ports
  logic signed [DW-1:0] mem [NUM_ENTRIES];
  logic                rd_en;
  logic [IDX_W-1:0]    rd_addr;
  logic signed [DW-1:0] rdata;
  logic                wr_en;
  logic [IDX_W-1:0]    wr_addr;
  logic signed [DW-1:0] wr_data;

  logic out_free;
  logic out_load;
  logic full;
  logic mismatch;
  logic rd_last;

  assign out_free = !out_valid || rsp.ready;
  // a new result enters the output register this cycle
  assign out_load = out_free && ((state == S_EMIT) || ((state == S_READ) && rvalid));
  assign full     = (len == LEN_W'(NUM_ENTRIES));
  assign mismatch = rvalid && (rdata != val_q);
  assign rd_last  = ((emit_idx + LEN_W'(1)) == len);
  assign rd_addr  = rd_ptr[IDX_W-1:0];

  // Store access. In a remove walk the write address (keep) never passes the
  // address of the data being compacted, so it always lags the read pointer:
  // a write never hits an entry still waiting to be read.
  always_comb begin
    rd_en   = 1'b0;
    wr_en   = 1'b0;
    wr_addr = len[IDX_W-1:0];
    wr_data = req.value;
    unique case (state)
      S_IDLE: begin
        wr_en = req.valid && (req.kind == lar_pkg::KIND_APPEND) && !full;
      end
      S_REMOVE: begin
        rd_en   = (rd_ptr < len);
        wr_en   = mismatch;
        wr_addr = keep[IDX_W-1:0];
        wr_data = rdata;
      end
      S_READ: begin
        // only fetch once the previous element can move on, so rdata holds
        rd_en = (rd_ptr < len) && (!rvalid || out_free);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      len       <= '0;
      rvalid    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // result taken and nothing new loaded behind it
      if (out_valid && rsp.ready && !out_load) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            val_q     <= req.value;
            rd_ptr    <= '0;
            keep      <= '0;
            emit_idx  <= '0;
            res_count <= '0;
            unique case (req.kind)
              lar_pkg::KIND_APPEND: begin
                if (full) begin
                  res_status <= lar_pkg::ST_FULL;
                end else begin
                  res_status <= lar_pkg::ST_APPENDED;
                  len        <= len + LEN_W'(1);
                end
                state <= S_EMIT;
              end
              lar_pkg::KIND_REMOVE: begin
                if (len == '0) begin
                  res_status <= lar_pkg::ST_EMPTY;
                  state      <= S_EMIT;
                end else begin
                  state <= S_REMOVE;
                end
              end
              lar_pkg::KIND_READ: begin
                if (len == '0) begin
                  res_status <= lar_pkg::ST_EMPTY;
                  state      <= S_EMIT;
                end else begin
                  state <= S_READ;
                end
              end
              default: begin
                // undefined kind: dropped without a result
              end
            endcase
          end
        end

        S_EMIT: begin
          if (out_free) begin
            out_valid   <= 1'b1;
            out_status  <= res_status;
            out_count   <= res_count;
            out_element <= val_q;
            out_last    <= 1'b1;
            state       <= S_IDLE;
          end
        end

        S_REMOVE: begin
          if (rd_en) begin
            rd_ptr <= rd_ptr + LEN_W'(1);
          end
          rvalid <= rd_en;
          if (mismatch) begin
            keep <= keep + LEN_W'(1);
          end
          // walk drained: all reads issued and the last compare done
          if (!rd_en && !rvalid) begin
            len <= keep;
            if (keep == len) begin
              res_status <= lar_pkg::ST_NOT_FOUND;
              res_count  <= '0;
            end else begin
              res_status <= lar_pkg::ST_REMOVED;
              res_count  <= CntW'(len - keep);
            end
            state <= S_EMIT;
          end
        end

        S_READ: begin
          if (rd_en) begin
            rd_ptr <= rd_ptr + LEN_W'(1);
          end
          rvalid <= rd_en || (rvalid && !out_free);
          if (rvalid && out_free) begin
            out_valid   <= 1'b1;
            out_status  <= lar_pkg::ST_ELEMENT;
            out_count   <= '0;
            out_element <= rdata;
            out_last    <= rd_last;
            emit_idx    <= emit_idx + LEN_W'(1);
            if (rd_last) begin
              state <= S_IDLE;
            end
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign req.ready         = (state == S_IDLE);
  assign rsp.valid         = out_valid;
  assign rsp.status        = out_status;
  assign rsp.removed_count = out_count;
  assign rsp.element       = out_element;
  assign rsp.last          = out_last;

endmodule

`default_nettype wire

// ----- design/lar_checker.sv -----
// Port-level checks for list_append_remove_all, attached by bind.
// Uses lar_pkg and the macros in list_append_remove_all_assert.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "list_append_remove_all_assert.svh"

module lar_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          req_ready,
  input wire logic                          rsp_valid,
  input wire logic                          rsp_ready,
  input wire logic [lar_pkg::STATUS_W-1:0]  rsp_status,
  input wire logic [lar_pkg::COUNT_W-1:0]   rsp_count,
  input wire logic                          rsp_last
);

  logic is_removed;
  logic is_element;

  assign is_removed = (rsp_status == lar_pkg::ST_REMOVED);
  assign is_element = (rsp_status == lar_pkg::ST_ELEMENT);

  // a pending result stays until taken
  `LAR_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "result dropped while stalled")
  // count is non-zero exactly on a removed result
  `LAR_ASSERT_NOW(a_count_zero, rsp_valid && !is_removed, rsp_count == '0, "stray removed count")
  `LAR_ASSERT_NOW(a_count_set, rsp_valid && is_removed, rsp_count != '0, "removed with zero count")
  // only a read-out has more than one result per item
  `LAR_ASSERT_NOW(a_single_last, rsp_valid && !is_element, rsp_last, "single result not last")
  // no new item is taken in the middle of a read-out
  `LAR_ASSERT_NOW(a_read_busy, rsp_valid && is_element && !rsp_last, !req_ready,
                  "item accepted during read-out")

endmodule

bind list_append_remove_all lar_checker u_lar_checker (
  .clk        (clk),
  .rst        (rst),
  .req_ready  (req.ready),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .rsp_status (rsp.status),
  .rsp_count  (rsp.removed_count),
  .rsp_last   (rsp.last)
);

`default_nettype wire
